>>> sv/bhp_pkg.sv
package bhp_pkg;

	// Uptime guards for release tracking, in ms
	localparam logic [31:0] RELEASE_GUARD_MS = 32'd3000;
	localparam logic [31:0] IDLE_GUARD_MS    = 32'd5000;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POWER_ON_HOLD = 3'd0,
		REG_START_HOLD    = 3'd1,
		REG_RESCUE_HOLD   = 3'd2,
		REG_STOP_HOLD     = 3'd3,
		REG_OFF_HOLD      = 3'd4,
		REG_IDLE_CUR_LOW  = 3'd5,
		REG_IDLE_CUR_HIGH = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		CMD_NONE       = 3'd0,
		CMD_POWER_ON   = 3'd1,
		CMD_START      = 3'd2,
		CMD_STOP       = 3'd3,
		CMD_POWER_OFF  = 3'd4,
		CMD_EMERG_MODE = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		WS_OFF   = 2'd0,
		WS_IDLE  = 2'd1,
		WS_ERROR = 2'd2,
		WS_OTHER = 2'd3
	} work_state_t;

	typedef struct packed {
		logic               emergency_pressed;
		logic               button_pressed;
		logic        [31:0] uptime_ms;
		logic        [1:0]  work_state;
		logic               system_protected;
		logic signed [15:0] output_current;
	} in_item_t;

	typedef struct packed {
		logic       emergency_stop;
		logic [2:0] command;
		logic       stop_request;
	} out_item_t;

endpackage

>>> sv/bhp_in_if.sv
interface bhp_in_if import bhp_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/bhp_out_if.sv
interface bhp_out_if import bhp_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/button_hold_power_controller.sv
// Channel   | Dir | Payload      | Transfer
// ----------+-----+--------------+---------------------------------
// in_ch     | in  | in_item_t    | in_ch.valid & in_ch.ready
// out_ch    | out | out_item_t   | out_ch.valid & out_ch.ready
// cfg       | in  | wr_index/data| wr_en high at clk edge
//
// One tick per clock sustained while out_ch.ready stays high. A tick is
// captured into the input stage, then evaluated against the hold state
// into the result register. arst_n clears both stage valids, the hold
// state and loads the register defaults. The input stage advances
// whenever the result register is empty or being drained, so a stalled
// output holds at most one tick in each stage before in_ch.ready drops.
module button_hold_power_controller import bhp_pkg::*; #(
	parameter int unsigned HOLD_COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	bhp_in_if.sink                in_ch,
	bhp_out_if.source             out_ch
);

	// Common width for comparing the counter against 8-bit thresholds
	localparam int unsigned CMP_W = (HOLD_COUNT_BITS > 8) ? HOLD_COUNT_BITS : 8;
	localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = '1;

	// Configuration registers
	logic        [7:0]  power_on_hold_q, start_hold_q, rescue_hold_q;
	logic        [7:0]  stop_hold_q, off_hold_q;
	logic signed [15:0] idle_low_q, idle_high_q;

	// Hold state
	logic [HOLD_COUNT_BITS-1:0] hold_q;
	logic                       released_q;
	logic                       last_btn_q;
	logic                       stop_flag_q;

	// Pipeline
	logic      s1_valid_q;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;
	logic      adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_on_hold_q <= 8'd1;
			start_hold_q    <= 8'd3;
			rescue_hold_q   <= 8'd30;
			stop_hold_q     <= 8'd2;
			off_hold_q      <= 8'd4;
			idle_low_q      <= -16'sd20;
			idle_high_q     <= 16'sd30;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_POWER_ON_HOLD: power_on_hold_q <= wr_data[7:0];
				REG_START_HOLD:    start_hold_q    <= wr_data[7:0];
				REG_RESCUE_HOLD:   rescue_hold_q   <= wr_data[7:0];
				REG_STOP_HOLD:     stop_hold_q     <= wr_data[7:0];
				REG_OFF_HOLD:      off_hold_q      <= wr_data[7:0];
				REG_IDLE_CUR_LOW:  idle_low_q      <= $signed(wr_data);
				REG_IDLE_CUR_HIGH: idle_high_q     <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	// Handshake: input stage moves on when the result slot is free or leaving
	assign adv          = s1_valid_q && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !s1_valid_q || adv;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.data;
		end
	end

	// Tick evaluation
	logic                       idle;
	logic [HOLD_COUNT_BITS-1:0] hold_base, hold_inc, hold_nxt;
	logic [CMP_W-1:0]           hold_cmp;
	logic                       rel_base, rel_nxt, last_base;
	logic                       stop_nxt;
	cmd_t                       cmd;
	logic                       btn;

	always_comb begin
		btn      = item_s1.button_pressed;
		idle     = (item_s1.output_current >= idle_low_q) &&
		           (item_s1.output_current <= idle_high_q);

		// Emergency contact clears the tracking first
		hold_base = item_s1.emergency_pressed ? '0 : hold_q;
		rel_base  = item_s1.emergency_pressed ? 1'b0 : released_q;
		last_base = item_s1.emergency_pressed ? 1'b0 : last_btn_q;
		stop_nxt  = item_s1.emergency_pressed ? 1'b1 : stop_flag_q;

		hold_inc = (hold_base == HOLD_MAX) ? hold_base : hold_base + HOLD_COUNT_BITS'(1);
		hold_cmp = CMP_W'(hold_base);
		hold_nxt = hold_base;
		cmd      = CMD_NONE;

		if (!btn && last_base && item_s1.uptime_ms >= RELEASE_GUARD_MS) begin
			rel_nxt = 1'b1;
		end else if (!btn && item_s1.uptime_ms >= IDLE_GUARD_MS) begin
			rel_nxt = (work_state_t'(item_s1.work_state) != WS_OFF);
		end else begin
			rel_nxt = rel_base;
		end

		if (rel_nxt) begin
			if (btn) begin
				priority if (hold_cmp >= CMP_W'(off_hold_q)) begin
					stop_nxt = 1'b1;
					if (idle) cmd = CMD_POWER_OFF;
				end else if (hold_cmp >= CMP_W'(stop_hold_q)) begin
					stop_nxt = 1'b1;
					if (idle) begin
						cmd      = CMD_STOP;
						hold_nxt = hold_inc;
					end
				end else begin
					hold_nxt = hold_inc;
				end
			end else begin
				hold_nxt = '0;
				stop_nxt = 1'b0;
			end
		end else begin
			if (btn) begin
				priority if (hold_cmp >= CMP_W'(rescue_hold_q)) begin
					// rescue hold: counter parks here
					if (item_s1.system_protected ||
					    work_state_t'(item_s1.work_state) == WS_ERROR) begin
						cmd = CMD_EMERG_MODE;
					end else if (work_state_t'(item_s1.work_state) == WS_IDLE) begin
						cmd = CMD_START;
					end
				end else if (hold_cmp >= CMP_W'(start_hold_q)) begin
					cmd      = CMD_START;
					hold_nxt = hold_inc;
				end else if (hold_cmp >= CMP_W'(power_on_hold_q)) begin
					cmd      = CMD_POWER_ON;
					hold_nxt = hold_inc;
				end else begin
					hold_nxt = hold_inc;
				end
			end else begin
				hold_nxt = '0;
			end
			stop_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= '0;
			released_q  <= 1'b0;
			last_btn_q  <= 1'b0;
			stop_flag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				hold_q      <= hold_nxt;
				released_q  <= rel_nxt;
				last_btn_q  <= btn;
				stop_flag_q <= stop_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.emergency_stop <= item_s1.emergency_pressed;
			out_q.command        <= cmd;
			out_q.stop_request   <= stop_nxt;
		end
	end

	// Released button always restarts the hold count
	a_hold_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !item_s1.button_pressed |=> hold_q == '0)
		else $error("hold count not cleared on release");

	// Last button level follows the evaluated tick
	a_last_btn: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> last_btn_q == $past(item_s1.button_pressed))
		else $error("last button level mismatch");

	// A stop request only comes from the released branch
	a_stop_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.stop_request |->
			(out_q.command == CMD_NONE || out_q.command == CMD_STOP ||
			 out_q.command == CMD_POWER_OFF))
		else $error("stop request with start-side command");

	// Emergency tick always reports emergency stop
	a_emerg: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.emergency_pressed |=> out_valid_q && out_q.emergency_stop)
		else $error("emergency stop not reported");

	// Result register is never overwritten while held
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !adv)
		else $error("result overwritten under stall");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import bhp_pkg::*;

	// Mirrors the hold/release logic tick by tick and keeps the replies still owed
	// by the block, oldest first.
	class tick_scoreboard;
		logic [7:0]         power_on_hold, start_hold, rescue_hold, stop_hold, off_hold;
		logic signed [15:0] idle_low, idle_high;
		logic [7:0]         hold_count;
		bit                 released, prev_button, stop_flag;
		out_item_t          awaited[$];
		int unsigned        mismatches, replies, emergency_stops;
		int unsigned        cmd_seen[8];

		function new();
			power_on_hold   = 8'd1;
			start_hold      = 8'd3;
			rescue_hold     = 8'd30;
			stop_hold       = 8'd2;
			off_hold        = 8'd4;
			idle_low        = -16'sd20;
			idle_high       = 16'sd30;
			hold_count      = 8'd0;
			released        = 1'b0;
			prev_button     = 1'b0;
			stop_flag       = 1'b0;
			mismatches      = 0;
			replies         = 0;
			emergency_stops = 0;
			foreach (cmd_seen[i]) cmd_seen[i] = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_POWER_ON_HOLD: power_on_hold = value[7:0];
				REG_START_HOLD:    start_hold    = value[7:0];
				REG_RESCUE_HOLD:   rescue_hold   = value[7:0];
				REG_STOP_HOLD:     stop_hold     = value[7:0];
				REG_OFF_HOLD:      off_hold      = value[7:0];
				REG_IDLE_CUR_LOW:  idle_low      = value;
				REG_IDLE_CUR_HIGH: idle_high     = value;
				default: ;
			endcase
		endfunction

		// counter saturates at all ones
		function void bump_hold();
			if (hold_count != 8'hFF) hold_count = hold_count + 8'd1;
		endfunction

		function out_item_t advance_hold_state(in_item_t t);
			logic signed [15:0] cur;
			bit                 idle, btn;
			cmd_t               cmd;
			out_item_t          r;
			cur  = t.output_current;
			btn  = t.button_pressed;
			idle = (cur >= idle_low) && (cur <= idle_high);
			cmd  = CMD_NONE;

			if (t.emergency_pressed) begin
				hold_count  = 8'd0;
				released    = 1'b0;
				prev_button = 1'b0;
				stop_flag   = 1'b1;
			end

			if (!btn && prev_button && t.uptime_ms >= RELEASE_GUARD_MS)
				released = 1'b1;
			else if (!btn && t.uptime_ms >= IDLE_GUARD_MS)
				released = (t.work_state != WS_OFF);

			if (released) begin
				if (btn) begin
					if (hold_count >= off_hold) begin
						stop_flag = 1'b1;
						if (idle) cmd = CMD_POWER_OFF;
					end else if (hold_count >= stop_hold) begin
						stop_flag = 1'b1;
						if (idle) begin
							cmd = CMD_STOP;
							bump_hold();
						end
					end else begin
						bump_hold();
					end
				end else begin
					hold_count = 8'd0;
					stop_flag  = 1'b0;
				end
			end else begin
				if (btn) begin
					if (hold_count >= rescue_hold) begin
						// counter parks here; only some states get a command
						if (t.system_protected || t.work_state == WS_ERROR)
							cmd = CMD_EMERG_MODE;
						else if (t.work_state == WS_IDLE)
							cmd = CMD_START;
					end else if (hold_count >= start_hold) begin
						cmd = CMD_START;
						bump_hold();
					end else if (hold_count >= power_on_hold) begin
						cmd = CMD_POWER_ON;
						bump_hold();
					end else begin
						bump_hold();
					end
				end else begin
					hold_count = 8'd0;
				end
				stop_flag = 1'b0;
			end

			prev_button      = btn;
			r.emergency_stop = t.emergency_pressed;
			r.command        = cmd;
			r.stop_request   = stop_flag;
			return r;
		endfunction

		function void note_tick(in_item_t t);
			awaited.push_back(advance_hold_state(t));
		endfunction

		function void check_reply(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				$error(
					"unexpected result: emergency_stop %0d command %0d stop_request %0d",
					got.emergency_stop, got.command, got.stop_request);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			replies++;
			if (got.emergency_stop !== want.emergency_stop) begin
				$error("emergency_stop: expected %0d, actual %0d",
					want.emergency_stop, got.emergency_stop);
				mismatches++;
			end
			if (got.command !== want.command) begin
				$error("command: expected %0d, actual %0d", want.command, got.command);
				mismatches++;
			end
			if (got.stop_request !== want.stop_request) begin
				$error("stop_request: expected %0d, actual %0d",
					want.stop_request, got.stop_request);
				mismatches++;
			end
			cmd_seen[want.command]++;
			if (want.emergency_stop) emergency_stops++;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	bhp_in_if  in_ch ();
	bhp_out_if out_ch ();

	tick_scoreboard sb = new();

	// sender burst state and receiver stall selection
	bit          gaps_on;
	int unsigned burst_left;
	int unsigned rx_mode;
	bit          hold_off_req;
	int unsigned ticks_sent;
	int unsigned settings_used;

	button_hold_power_controller dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block wedges or drops a result.
	initial begin
		#400_000;
		$display("button_hold_power_controller regression: fail");
		$finish;
	end

	function automatic in_item_t tick(bit emerg, bit btn, logic [31:0] up,
			work_state_t ws, bit prot, logic signed [15:0] cur);
		in_item_t t;
		t.emergency_pressed = emerg;
		t.button_pressed    = btn;
		t.uptime_ms         = up;
		t.work_state        = ws;
		t.system_protected  = prot;
		t.output_current    = cur;
		return t;
	endfunction

	// Offer one tick and wait for its transfer. Gaps come between bursts of
	// random length. ready is read right after the edge, i.e. its pre-edge value,
	// which is what the block saw at that edge.
	task automatic push_tick(in_item_t t);
		int unsigned gap;
		gap = 0;
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 8);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= t;
		do begin
			@(posedge clk);
		end while (in_ch.ready !== 1'b1);
		sb.note_tick(t);
		ticks_sent++;
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic drain_replies();
		in_ch.valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	// One register write per edge; the caller drops wr_en after the group.
	task automatic set_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic apply_settings(int p);
		logic [7:0]  h[5];
		logic [15:0] lo, hi;
		int unsigned k;
		case (p)
			0: begin
				// reset values, written explicitly
				h  = '{8'd1, 8'd3, 8'd30, 8'd2, 8'd4};
				lo = 16'hFFEC;
				hi = 16'd30;
			end
			1: begin
				// all thresholds zero, widest window
				h  = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
				lo = 16'h8000;
				hi = 16'h7FFF;
			end
			2: begin
				// all thresholds at max, widest window; pairs with a long hold
				h  = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
				lo = 16'h8000;
				hi = 16'h7FFF;
			end
			3: begin
				// ordered thresholds, empty window (low above high)
				h[0] = 8'($urandom_range(0, 3));
				h[1] = h[0] + 8'($urandom_range(0, 3));
				h[2] = h[1] + 8'($urandom_range(0, 6));
				h[3] = 8'($urandom_range(0, 3));
				h[4] = h[3] + 8'($urandom_range(0, 3));
				lo   = 16'd1;
				hi   = 16'd0;
			end
			4: begin
				for (k = 0; k < 5; k++) h[k] = 8'($urandom_range(0, 8));
				lo = 16'(-int'($urandom_range(0, 200)));
				hi = 16'($urandom_range(0, 200));
			end
			5: begin
				// single-point window
				for (k = 0; k < 5; k++) h[k] = 8'($urandom_range(0, 8));
				lo = 16'($urandom_range(0, 65535));
				hi = lo;
			end
			default: begin
				// overlapping thresholds, window anywhere (maybe empty)
				for (k = 0; k < 5; k++) h[k] = 8'($urandom_range(0, 8));
				lo = 16'($urandom);
				hi = 16'($urandom);
			end
		endcase
		set_register(REG_POWER_ON_HOLD, {8'd0, h[0]});
		set_register(REG_START_HOLD,    {8'd0, h[1]});
		set_register(REG_RESCUE_HOLD,   {8'd0, h[2]});
		set_register(REG_STOP_HOLD,     {8'd0, h[3]});
		set_register(REG_OFF_HOLD,      {8'd0, h[4]});
		set_register(REG_IDLE_CUR_LOW,  lo);
		set_register(REG_IDLE_CUR_HIGH, hi);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	// Mostly press/release sessions with a drifting uptime and currents around
	// the idle window edges; some raw noise ticks, stray emergencies and state
	// flips break the sessions up. long_first opens with a 258-tick hold so the
	// counter reaches all ones.
	task automatic run_random(int unsigned n_items, bit long_first);
		in_item_t    t;
		logic [63:0] raw;
		logic [31:0] up;
		logic [1:0]  ws;
		bit          prot, long_run;
		int unsigned sent, len, rel, k, cap;
		int          lo, hi, v;
		cap = 32'(sb.off_hold);
		if (32'(sb.rescue_hold) > cap) cap = 32'(sb.rescue_hold);
		if (32'(sb.start_hold) > cap) cap = 32'(sb.start_hold);
		if (cap > 40) cap = 40;
		sent = 0;
		up   = 32'd0;
		while (sent < n_items) begin
			if (!long_first && $urandom_range(0, 9) == 0) begin
				raw = {$urandom, $urandom};
				t   = raw[$bits(in_item_t)-1:0];
				push_tick(t);
				sent++;
			end else begin
				long_run   = long_first;
				long_first = 1'b0;
				// uptime start: below, around and above both guards, and near wrap
				case ($urandom_range(0, 5))
					0:       up = $urandom_range(0, 2999);
					1:       up = $urandom_range(2990, 3010);
					2:       up = $urandom_range(4990, 5010);
					3:       up = $urandom_range(3000, 4999);
					4:       up = $urandom;
					default: up = 32'hFFFF_F000 + $urandom_range(0, 4095);
				endcase
				ws   = 2'($urandom_range(0, 3));
				prot = ($urandom_range(0, 4) == 0);
				if (long_run) begin
					len  = 258;
					ws   = WS_IDLE;
					prot = 1'b1;
				end else begin
					len = $urandom_range(1, cap + 3);
				end
				rel = $urandom_range(1, 3);
				for (k = 0; k < len + rel; k++) begin
					lo = int'(sb.idle_low);
					hi = int'(sb.idle_high);
					case ($urandom_range(0, 5))
						0:       v = lo;
						1:       v = hi;
						2:       v = lo - 1;
						3:       v = hi + 1;
						4:       v = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo))
						                        : int'($urandom);
						default: v = int'($urandom);
					endcase
					t.emergency_pressed = !long_run && ($urandom_range(0, 39) == 0);
					t.button_pressed    = (k < len);
					t.uptime_ms         = up;
					t.work_state        = ($urandom_range(0, 9) == 0) ? 2'($urandom) : ws;
					t.system_protected  = prot;
					t.output_current    = v[15:0];
					push_tick(t);
					sent++;
					up = up + $urandom_range(0, 1500);
				end
			end
		end
	endtask

	// Receiver: checks each result transfer, then picks ready for the next edge.
	// A hold-off request forces ready low for a counted stretch so both stages
	// fill and in_ch.ready drops while the sender keeps offering.
	initial begin
		int unsigned rx_cycle, stall_left, hold_left;
		rx_cycle   = 0;
		stall_left = 0;
		hold_left  = 0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) sb.check_reply(out_ch.data);
			rx_cycle++;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = 40;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= ($urandom_range(0, 3) != 0);
					2: out_ch.ready <= ((rx_cycle % 7) >= 2);
					default: begin
						if (stall_left != 0) begin
							stall_left--;
							out_ch.ready <= 1'b0;
						end else if ($urandom_range(0, 9) == 0) begin
							stall_left = $urandom_range(1, 12);
							out_ch.ready <= 1'b0;
						end else begin
							out_ch.ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	initial begin
		int p;
		arst_n      <= 1'b0;
		wr_en       <= 1'b0;
		wr_index    <= '0;
		wr_data     <= '0;
		in_ch.valid <= 1'b0;
		in_ch.data  <= '0;
		gaps_on       = 1'b1;
		burst_left    = 0;
		rx_mode       = 1;
		hold_off_req  = 1'b0;
		ticks_sent    = 0;
		settings_used = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, reset thresholds: power-on then start while never released.
		push_tick(tick(1'b0, 1'b1, 32'd0, WS_IDLE, 1'b0, 16'sd0));
		push_tick(tick(1'b0, 1'b1, 32'd0, WS_IDLE, 1'b0, 16'sd0));
		push_tick(tick(1'b0, 1'b1, 32'd0, WS_IDLE, 1'b0, 16'sd0));
		push_tick(tick(1'b0, 1'b1, 32'd0, WS_IDLE, 1'b0, 16'sd0));
		// let go just under the 3 s guard: no release
		push_tick(tick(1'b0, 1'b0, 32'd2999, WS_IDLE, 1'b0, 16'sd0));
		push_tick(tick(1'b0, 1'b1, 32'd3000, WS_IDLE, 1'b0, 16'sd0));
		// let go exactly at 3 s: released
		push_tick(tick(1'b0, 1'b0, 32'd3000, WS_IDLE, 1'b0, 16'sd0));
		// released: hold through stop into power-off, current on both window edges
		push_tick(tick(1'b0, 1'b1, 32'd4000, WS_IDLE, 1'b0, 16'sd30));
		push_tick(tick(1'b0, 1'b1, 32'd4000, WS_IDLE, 1'b0, -16'sd20));
		push_tick(tick(1'b0, 1'b1, 32'd4000, WS_IDLE, 1'b0, 16'sd30));
		push_tick(tick(1'b0, 1'b1, 32'd4000, WS_IDLE, 1'b0, -16'sd20));
		push_tick(tick(1'b0, 1'b1, 32'd4000, WS_IDLE, 1'b0, 16'sd0));
		// just outside the window: flag only, no command
		push_tick(tick(1'b0, 1'b1, 32'd4000, WS_IDLE, 1'b0, 16'sd31));
		push_tick(tick(1'b0, 1'b1, 32'd4000, WS_IDLE, 1'b0, -16'sd21));
		// emergency while pressed clears everything
		push_tick(tick(1'b1, 1'b1, 32'd4000, WS_IDLE, 1'b0, 16'sd0));
		push_tick(tick(1'b0, 1'b0, 32'd4999, WS_OFF, 1'b0, 16'sd0));
		// 5 s guard: released follows work state
		push_tick(tick(1'b0, 1'b0, 32'd5000, WS_OFF, 1'b0, 16'sd0));
		push_tick(tick(1'b0, 1'b0, 32'd5000, WS_OTHER, 1'b0, 16'sd0));
		push_tick(tick(1'b0, 1'b0, 32'hFFFF_FFFF, WS_ERROR, 1'b0, 16'sd0));
		push_tick(tick(1'b1, 1'b0, 32'hFFFF_FFFF, WS_OFF, 1'b0, 16'sd0));

		// Overlapping low thresholds to reach rescue quickly.
		drain_replies();
		set_register(REG_POWER_ON_HOLD, 16'd0);
		set_register(REG_START_HOLD, 16'd1);
		set_register(REG_RESCUE_HOLD, 16'd2);
		set_register(REG_STOP_HOLD, 16'd0);
		set_register(REG_OFF_HOLD, 16'd1);
		wr_en <= 1'b0;
		settings_used++;
		push_tick(tick(1'b0, 1'b1, 32'd0, WS_OTHER, 1'b0, 16'sh8000));
		push_tick(tick(1'b0, 1'b1, 32'd0, WS_OTHER, 1'b0, 16'sh8000));
		// at rescue: other state gives nothing, then idle, protected, error
		push_tick(tick(1'b0, 1'b1, 32'd0, WS_OTHER, 1'b0, 16'sh7FFF));
		push_tick(tick(1'b0, 1'b1, 32'd0, WS_IDLE, 1'b0, 16'sh7FFF));
		push_tick(tick(1'b0, 1'b1, 32'd0, WS_OTHER, 1'b1, 16'sh7FFF));
		push_tick(tick(1'b0, 1'b1, 32'd0, WS_ERROR, 1'b0, 16'sh8000));
		push_tick(tick(1'b0, 1'b0, 32'd3000, WS_OTHER, 1'b0, 16'sd0));
		push_tick(tick(1'b0, 1'b1, 32'd3100, WS_OTHER, 1'b0, 16'sd0));
		push_tick(tick(1'b0, 1'b1, 32'd3200, WS_OTHER, 1'b0, 16'sd0));

		// Random phases, each under its own register setting and handshake mix.
		// Phase 4 runs with no idling on either side.
		for (p = 0; p < 8; p++) begin
			drain_replies();
			apply_settings(p);
			rx_mode = p % 4;
			gaps_on = (p % 3 != 1);
			if (p == 5) begin
				// sender pauses mid-phase until all results are in
				run_random(25, 1'b0);
				drain_replies();
				run_random(25, 1'b0);
			end else begin
				if (p == 6) hold_off_req = 1'b1;
				run_random(50, p == 2);
			end
		end

		drain_replies();
		repeat (10) @(posedge clk);
		if (sb.awaited.size() != 0) begin
			$error("%0d results never arrived", sb.awaited.size());
			sb.mismatches++;
		end
		$display("Sent %0d ticks under %0d register settings; %0d results checked.",
			ticks_sent, settings_used, sb.replies);
		$display(
			"Commands: power-on %0d, start %0d, stop %0d, power-off %0d, emergency mode %0d;",
			sb.cmd_seen[CMD_POWER_ON], sb.cmd_seen[CMD_START], sb.cmd_seen[CMD_STOP],
			sb.cmd_seen[CMD_POWER_OFF], sb.cmd_seen[CMD_EMERG_MODE]);
		$display("%0d emergency stops.", sb.emergency_stops);
		if (sb.mismatches == 0)
			$display("button_hold_power_controller regression: pass");
		else
			$display("button_hold_power_controller regression: fail");
		$finish;
	end

endmodule
